// File: rtl/core/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types and codes for the utf-8 stream decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int LEN_W  = 3;
    localparam int ST_W   = 2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_CONT = 2'd2;

    // classification of a byte seen while idle
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] cont_count;
        logic [6:0]       payload;
    } lead_t;

    // one decoded result
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] seq_length;
        logic [CP_W-1:0]  code_point;
    } result_t;

endpackage

// File: rtl/core/u8d_lead_decode.sv
// ----------------------------------------------------------------------------
// u8d_lead_decode
// classifies a lead byte into continuation count and payload bits
// ----------------------------------------------------------------------------
module u8d_lead_decode
(
    input  logic [u8d_pkg::BYTE_W-1:0] lead_byte,
    output u8d_pkg::lead_t             lead
);

    always_comb
    begin
        lead = '0;
        unique case (lead_byte) inside
            8'b0???????:
            begin
                lead.valid      = 1'b1;
                lead.cont_count = 3'd0;
                lead.payload    = lead_byte[6:0];
            end
            8'b110?????:
            begin
                lead.valid      = 1'b1;
                lead.cont_count = 3'd1;
                lead.payload    = {2'b00, lead_byte[4:0]};
            end
            8'b1110????:
            begin
                lead.valid      = 1'b1;
                lead.cont_count = 3'd2;
                lead.payload    = {3'b000, lead_byte[3:0]};
            end
            8'b11110???:
            begin
                lead.valid      = 1'b1;
                lead.cont_count = 3'd3;
                lead.payload    = {4'b0000, lead_byte[2:0]};
            end
            8'b111110??:
            begin
                lead.valid      = 1'b1;
                lead.cont_count = 3'd4;
                lead.payload    = {5'b00000, lead_byte[1:0]};
            end
            8'b1111110?:
            begin
                lead.valid      = 1'b1;
                lead.cont_count = 3'd5;
                lead.payload    = {6'b000000, lead_byte[0]};
            end
            default:
            begin
                // stray continuation byte or 0xfe / 0xff
                lead = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/u8d_seq.sv
// ----------------------------------------------------------------------------
// u8d_seq
// sequence state and per-byte update, one byte per enabled cycle
// ----------------------------------------------------------------------------
module u8d_seq
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  logic [u8d_pkg::BYTE_W-1:0] step_byte,
    output logic                       res_valid,
    output u8d_pkg::result_t           res
);

    logic [u8d_pkg::CP_W-1:0]  acc_reg,    acc_next;
    logic [u8d_pkg::LEN_W-1:0] remain_reg, remain_next;
    logic [u8d_pkg::LEN_W-1:0] len_reg,    len_next;
    u8d_pkg::lead_t            lead;
    logic [u8d_pkg::CP_W-1:0]  acc_shift;
    logic [u8d_pkg::LEN_W-1:0] len_inc;

    u8d_lead_decode u_lead
    (
        .lead_byte (step_byte),
        .lead      (lead)
    );

    assign acc_shift = {acc_reg[u8d_pkg::CP_W-7:0], step_byte[5:0]};
    assign len_inc   = len_reg + 3'd1;

    always_comb
    begin
        acc_next    = acc_reg;
        remain_next = remain_reg;
        len_next    = len_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (step_en)
        begin
            if (remain_reg == 3'd0)
            begin
                if (!lead.valid)
                begin
                    res_valid      = 1'b1;
                    res.status     = u8d_pkg::ST_BAD_LEAD;
                    res.seq_length = 3'd1;
                end
                else if (lead.cont_count == 3'd0)
                begin
                    // single-byte ascii
                    res_valid      = 1'b1;
                    res.status     = u8d_pkg::ST_OK;
                    res.seq_length = 3'd1;
                    res.code_point = {24'd0, lead.payload};
                end
                else
                begin
                    acc_next    = {24'd0, lead.payload};
                    remain_next = lead.cont_count;
                    len_next    = 3'd1;
                end
            end
            else if (step_byte[7:6] != 2'b10)
            begin
                // broken continuation: drop the partial sequence
                res_valid      = 1'b1;
                res.status     = u8d_pkg::ST_BAD_CONT;
                res.seq_length = len_inc;
                acc_next       = '0;
                remain_next    = 3'd0;
                len_next       = 3'd0;
            end
            else if (remain_reg == 3'd1)
            begin
                res_valid      = 1'b1;
                res.status     = u8d_pkg::ST_OK;
                res.seq_length = len_inc;
                res.code_point = acc_shift;
                acc_next       = '0;
                remain_next    = 3'd0;
                len_next       = 3'd0;
            end
            else
            begin
                acc_next    = acc_shift;
                remain_next = remain_reg - 3'd1;
                len_next    = len_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            remain_reg <= '0;
            len_reg    <= '0;
        end
        else
        begin
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            len_reg    <= len_next;
        end
    end

endmodule

// File: rtl/core/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// byte-serial decoder for the original six-byte utf-8 form
// ----------------------------------------------------------------------------
// Takes one byte per input transaction and sustains one byte per cycle while the
// output is not stalled. Each byte is captured in an input register, goes through
// the lead classifier and the accumulator update in a single pass, and any result
// lands in an output register. A completed sequence gives one result with the
// code point (up to 31 bits) and its length; continuation bytes that do not close
// a sequence give no result. A bad lead byte gives status 1, a bad continuation
// byte gives status 2 with the bytes taken so far, and in both cases the byte is
// dropped and the decoder returns to idle. Overlong forms are decoded as they are.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [30:0] code_point, [33:31] seq_length, zero pad
    output logic [1:0]  m_tuser    // [1:0] status
);

    // input register
    logic                        in_valid_reg;
    logic [u8d_pkg::BYTE_W-1:0]  in_byte_reg;

    // output register
    logic                        out_valid_reg;
    u8d_pkg::result_t            out_res_reg;

    logic                        advance;
    logic                        step_en;
    logic                        res_valid;
    u8d_pkg::result_t            res;

    // the pipe moves whenever the output register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    u8d_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .step_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.seq_length, out_res_reg.code_point};
    assign m_tuser  = out_res_reg.status;

endmodule

// File: sim/utf8_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// self-checking bench for the six-byte utf-8 stream decoder
// ----------------------------------------------------------------------------
// Feeds a byte stream into the decoder and checks every decoded transaction
// against a cycle-free decoder model kept inside the bench. The stream opens
// with hand-picked sequences (ascii limits, the largest code point, bad lead
// bytes, a sequence cut short) and goes on with random well-formed sequences
// of every length, mixed with broken sequences and raw noise bytes. Both the
// byte source and the result sink insert random gaps and stalls.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

    localparam int N_DIRECTED = 24;
    localparam int N_BYTES    = 950;
    localparam int IDLE_LIMIT = 2000;   // cycles with no transaction on either side
    localparam int MAX_REPORTS = 20;

    // hand-picked opening stream
    localparam logic [7:0] DIRECTED [N_DIRECTED] = '{
        8'h00, 8'hFF, 8'h7F, 8'h80,                        // ascii limits, bad leads
        8'hC0, 8'h80,                                      // overlong two-byte zero
        8'hEF, 8'hBF, 8'hBF,                               // three-byte maximum
        8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,          // largest 31-bit value
        8'hFE,                                             // bad lead
        8'hF8, 8'h88, 8'h80, 8'h80, 8'hC0,                 // five-byte cut by a lead-like byte
        8'hE2, 8'h82, 8'hAC                                // ordinary three-byte sequence
    };

    typedef struct {
        logic [7:0] data;
        bit         drain_first;   // hold off until all results are back
    } feed_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [30:0] code_point, [33:31] seq_length, zero pad
    logic [1:0]  m_tuser;          // [1:0] status

    feed_t            byte_feed [$];
    u8d_pkg::result_t decoded_due [$];

    // decoder model state
    logic [u8d_pkg::CP_W-1:0]  acc_bits   = '0;
    logic [u8d_pkg::LEN_W-1:0] conts_left = '0;
    logic [u8d_pkg::LEN_W-1:0] taken      = '0;

    int bytes_sent   = 0;
    int total_bytes  = 0;
    int errors       = 0;
    int n_ok         = 0;
    int n_bad_lead   = 0;
    int n_bad_cont   = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;

    utf8_stream_decoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // one byte through the decoder model; produced says whether a result comes out
    function automatic void utf8_decode_step(input logic [7:0] b, output bit produced,
                                             output u8d_pkg::result_t res);
        logic [u8d_pkg::LEN_W-1:0] cnt;
        logic [6:0]                pay;
        bit                        lead_ok;
        produced = 1'b0;
        res      = '0;
        cnt      = '0;
        pay      = '0;
        lead_ok  = 1'b1;
        if (conts_left == 0)
        begin
            casez (b)
                8'b0???????: begin cnt = 3'd0; pay = b[6:0];          end
                8'b110?????: begin cnt = 3'd1; pay = {2'b0, b[4:0]}; end
                8'b1110????: begin cnt = 3'd2; pay = {3'b0, b[3:0]}; end
                8'b11110???: begin cnt = 3'd3; pay = {4'b0, b[2:0]}; end
                8'b111110??: begin cnt = 3'd4; pay = {5'b0, b[1:0]}; end
                8'b1111110?: begin cnt = 3'd5; pay = {6'b0, b[0]};   end
                default:     lead_ok = 1'b0;
            endcase
            if (!lead_ok)
            begin
                // stray continuation or 0xfe/0xff: dropped, stay idle
                produced       = 1'b1;
                res.status     = u8d_pkg::ST_BAD_LEAD;
                res.seq_length = 3'd1;
            end
            else if (cnt == 0)
            begin
                produced       = 1'b1;
                res.status     = u8d_pkg::ST_OK;
                res.seq_length = 3'd1;
                res.code_point = {24'b0, pay};
            end
            else
            begin
                acc_bits   = {24'b0, pay};
                conts_left = cnt;
                taken      = 3'd1;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            // broken sequence: offending byte is dropped, not taken as a new lead
            produced       = 1'b1;
            res.status     = u8d_pkg::ST_BAD_CONT;
            res.seq_length = taken + 3'd1;
            acc_bits       = '0;
            conts_left     = '0;
            taken          = '0;
        end
        else
        begin
            acc_bits   = {acc_bits[u8d_pkg::CP_W-7:0], b[5:0]};
            taken      = taken + 3'd1;
            conts_left = conts_left - 3'd1;
            if (conts_left == 0)
            begin
                produced       = 1'b1;
                res.status     = u8d_pkg::ST_OK;
                res.seq_length = taken;
                res.code_point = acc_bits;
                acc_bits       = '0;
                taken          = '0;
            end
        end
    endfunction

    // lead byte for a sequence of n bytes, payload bits random
    function automatic logic [7:0] lead_byte(input int n);
        logic [7:0] r;
        r = 8'($urandom);
        case (n)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            4:       return {5'b11110, r[2:0]};
            5:       return {6'b111110, r[1:0]};
            default: return {7'b1111110, r[0]};
        endcase
    endfunction

    function automatic void feed(input logic [7:0] b);
        feed_t f;
        f.data        = b;
        // drain once where the random part starts, then now and then
        f.drain_first = (byte_feed.size() == N_DIRECTED) || (byte_feed.size() % 320 == 160);
        byte_feed.push_back(f);
    endfunction

    // byte source: one transaction per feed entry, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        feed_t            nxt;
        u8d_pkg::result_t res;
        bit               produced;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            gap_left   = 0;
            acc_bits   = '0;
            conts_left = '0;
            taken      = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                utf8_decode_step(s_tdata, produced, res);
                if (produced)
                begin
                    decoded_due.push_back(res);
                    case (res.status)
                        u8d_pkg::ST_OK:       n_ok++;
                        u8d_pkg::ST_BAD_LEAD: n_bad_lead++;
                        default:              n_bad_cont++;
                    endcase
                end
                bytes_sent++;
                if ($urandom_range(0, 49) == 0)
                    tx_steady = ~tx_steady;
            end
            if (s_tvalid && !s_tready)
            begin
                // keep the offered byte until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (byte_feed.size() != 0 &&
                     !(byte_feed[0].drain_first && decoded_due.size() != 0))
            begin
                nxt = byte_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                gap_left = tx_steady ? 0 : $urandom_range(0, 8);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result sink: checks each transaction, random stall after each
    always @(posedge clk or negedge rst_n)
    begin
        u8d_pkg::result_t want;
        int               stall;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result cp=%h len=%0d st=%0d", $time,
                                 m_tdata[30:0], m_tdata[33:31], m_tuser);
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (m_tdata[30:0] !== want.code_point || m_tdata[33:31] !== want.seq_length
                        || m_tuser !== want.status)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: mismatch expected cp=%h len=%0d st=%0d,",
                                      " got cp=%h len=%0d st=%0d"},
                                     $time, want.code_point, want.seq_length, want.status,
                                     m_tdata[30:0], m_tdata[33:31], m_tuser);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_steady = ~rx_steady;
                stall = rx_steady ? 0 : $urandom_range(0, 8);
                if (stall == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready   <= 1'b0;
                    stall_left = stall;
                end
            end
            else if (!m_tready)
            begin
                if (stall_left <= 1)
                begin
                    m_tready   <= 1'b1;
                    stall_left = 0;
                end
                else
                    stall_left--;
            end
        end
    end

    // watchdog on transaction activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("[utf8_stream_decoder] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int         kind;
        int         n;
        int         cut;
        logic [7:0] bad;

        foreach (DIRECTED[i])
            feed(DIRECTED[i]);

        // random part: mostly well-formed sequences, some cut short, some noise
        while (byte_feed.size() < N_BYTES)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 10)
                feed(8'($urandom_range(0, 255)));
            else
            begin
                n = $urandom_range(1, 6);
                feed(lead_byte(n));
                if (kind < 28 && n > 1)
                begin
                    cut = $urandom_range(0, n - 2);
                    repeat (cut)
                        feed({2'b10, 6'($urandom)});
                    do
                        bad = 8'($urandom_range(0, 255));
                    while (bad[7:6] == 2'b10);
                    feed(bad);
                end
                else
                    repeat (n - 1)
                        feed({2'b10, 6'($urandom)});
            end
        end
        total_bytes = byte_feed.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_sent != total_bytes || decoded_due.size() != 0)
            @(negedge clk);
        // catch any stray result that comes out after the last expected one
        repeat (10) @(negedge clk);

        $display("bytes decoded: %0d, code points: %0d, bad leads: %0d,",
                 bytes_sent, n_ok, n_bad_lead);
        $display("broken sequences: %0d, mismatches: %0d", n_bad_cont, errors);
        if (errors == 0)
            $display("[utf8_stream_decoder] OK");
        else
            $display("[utf8_stream_decoder] ERROR");
        $finish;
    end

endmodule

// File: utf8_stream_decoder.f
rtl/core/u8d_pkg.sv
rtl/core/u8d_lead_decode.sv
rtl/core/u8d_seq.sv
rtl/core/utf8_stream_decoder.sv
sim/utf8_stream_decoder_tb.sv
